// ===== sv/drst_pkg.sv =====
package drst_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int XY_W   = 16;
  localparam int Z_W    = 24;
  localparam int PIX_W  = 11;  // truncated Q12.4 coordinate, clipped to >= 0
  localparam int DIM_W  = 9;
  localparam int BIAS_W = 23;
  localparam int CNT_W  = 17;
  localparam int LIM_W  = 14;  // signed room for pixel coords and map limits
  localparam int AREA_W = 35;
  localparam int E_W    = 37;
  localparam int NUM_W  = 60;
  localparam int MAG_W  = 59;
  localparam int MUL_AW = 19;
  localparam int MUL_BW = 25;
  localparam int PROD_W = MUL_AW + MUL_BW;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [Z_W-1:0]   DEPTH_MAX = 24'h7FFFFF;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TRI   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_DEPTH_BIAS = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_TRI,
    CMD_QUERY,
    CMD_DEGEN,
    CMD_OUTSIDE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_QREAD,
    B_QCMP,
    B_EDGE,
    B_COVER,
    B_DEPTH,
    B_DIVINIT,
    B_DIV,
    B_WRITE,
    B_NEXT
  } back_state_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [XY_W-1:0]   vx0;
    logic signed [XY_W-1:0]   vy0;
    logic signed [Z_W-1:0]    vz0;
    logic signed [XY_W-1:0]   vx1;
    logic signed [XY_W-1:0]   vy1;
    logic signed [Z_W-1:0]    vz1;
    logic signed [XY_W-1:0]   vx2;
    logic signed [XY_W-1:0]   vy2;
    logic signed [Z_W-1:0]    vz2;
  } in_word_t;

  typedef struct packed {
    logic             in_shadow;
    logic             outside_map;
    logic [CNT_W-1:0] pixels_written;
    logic             degenerate;
  } res_word_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic signed [XY_W-1:0] x0;
    logic signed [XY_W-1:0] y0;
    logic signed [XY_W-1:0] x1;
    logic signed [XY_W-1:0] y1;
    logic signed [XY_W-1:0] x2;
    logic signed [XY_W-1:0] y2;
    logic signed [Z_W-1:0]  z0;
    logic signed [Z_W-1:0]  z1;
    logic signed [Z_W-1:0]  z2;
    logic [AREA_W-1:0]      area;
    logic                   area_neg;
    logic [PIX_W-1:0]       xa;
    logic [PIX_W-1:0]       xb;
    logic [PIX_W-1:0]       ya;
    logic [PIX_W-1:0]       yb;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t data;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Q12.4 to whole pixels, truncated toward zero
  function automatic logic signed [11:0] pix_trunc(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    t = v[XY_W-1] ? v + 16'sd15 : v;
    return t[XY_W-1:4];
  endfunction

  function automatic logic signed [11:0] smin3(input logic signed [11:0] a,
                                               input logic signed [11:0] b,
                                               input logic signed [11:0] c);
    logic signed [11:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [11:0] smax3(input logic signed [11:0] a,
                                               input logic signed [11:0] b,
                                               input logic signed [11:0] c);
    logic signed [11:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

// ===== sv/depth_map_rasterizer_shadow_test.sv =====
// Depth map rasterizer with shadow test. A command word (clear, triangle or
// query) is taken when start is high and busy is low; every command returns
// exactly one result word, marked by a one-cycle done strobe. The receiver
// cannot stall: done/result are shown for a single cycle and must be taken.
// The front end steps each word through capture, area multiply and classify
// and hands off through a 2-entry queue, so a new word can be taken while the
// back end is still working. The back end is built on one shared 19x25
// multiplier, a 24-step restoring divider and the map RAM (one read and one
// write per cycle). Its steps per word:
//   clear     - pop, then write every map entry to maximum depth
//               (one entry per cycle)
//   query     - pop, RAM read, compare
//   triangle  - pop, then per bounding-box pixel: edges and cover test; a
//               covered pixel adds depth sum, divide and write
//   degenerate, empty-box, outside-map or unknown words - pop only
// done is registered and rises the cycle after the back end finishes a word.
// After reset the map is swept to maximum depth; busy stays high until the
// sweep ends. Config registers are written through the cfg channel (always
// ready) and must only change while the block is idle.
module depth_map_rasterizer_shadow_test import drst_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              start,
  output logic              busy,
  input  in_word_t          cmd,
  // result channel
  output logic              done,
  output res_word_t         result,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [BIAS_W-1:0] cfg_data
);

  // config registers
  logic [DIM_W-1:0]  map_width;
  logic [DIM_W-1:0]  map_height;
  logic [BIAS_W-1:0] depth_bias;

  q_push_t   q_in;
  q_status_t q_stat;
  entry_t    head;
  logic      pop;
  logic      sweeping;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DIM_W'(256);
      map_height <= DIM_W'(256);
      depth_bias <= BIAS_W'(4194);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT: map_height <= cfg_data[DIM_W-1:0];
        REG_DEPTH_BIAS: depth_bias <= cfg_data;
        default:        depth_bias <= depth_bias;  // unknown index: dropped
      endcase
    end
  end

  // front: takes the word, computes doubled area and clipped box, classifies
  drst_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .hold      (sweeping),
    .cmd       (cmd),
    .map_width (map_width),
    .map_height(map_height),
    .q_stat    (q_stat),
    .busy      (busy),
    .q_in      (q_in)
  );

  // short queue decoupling classification from execution
  drst_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .q_in  (q_in),
    .pop   (pop),
    .q_stat(q_stat),
    .head  (head)
  );

  // back: owns the depth RAM, walks pixels, runs the divider, emits results
  drst_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .depth_bias(depth_bias),
    .pop       (pop),
    .sweeping  (sweeping),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== sv/drst_front.sv =====
module drst_front import drst_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             hold,
  input  in_word_t         cmd,
  input  logic [DIM_W-1:0] map_width,
  input  logic [DIM_W-1:0] map_height,
  input  q_status_t        q_stat,
  output logic             busy,
  output q_push_t          q_in
);

  front_state_t state, state_next;
  in_word_t w;
  logic signed [33:0] pa, pb;
  logic signed [LIM_W-1:0] bxa, bxb, bya, byb;

  logic accept;
  logic [LIM_W-1:0] mw, mh, effw, effh;
  logic signed [LIM_W-1:0] lim_x, lim_y;
  logic signed [16:0] ax1, ay2, ax2, ay1;
  logic signed [11:0] tx0, tx1, tx2, ty0, ty1, ty2, tmin_x, tmax_x, tmin_y, tmax_y;
  logic signed [LIM_W-1:0] emin_x, emax_x, emin_y, emax_y;
  logic signed [AREA_W-1:0] area;
  logic signed [LIM_W-1:0] qx, qy;
  logic q_out, box_empty;
  entry_t ent;

  assign mw    = {{(LIM_W-DIM_W){1'b0}}, map_width};
  assign mh    = {{(LIM_W-DIM_W){1'b0}}, map_height};
  assign effw  = (mw > LIM_W'(MAX_WIDTH)) ? LIM_W'(MAX_WIDTH) : mw;
  assign effh  = (mh > LIM_W'(MAX_HEIGHT)) ? LIM_W'(MAX_HEIGHT) : mh;
  assign lim_x = signed'(effw - LIM_W'(1));
  assign lim_y = signed'(effh - LIM_W'(1));

  assign ax1 = {w.vx1[XY_W-1], w.vx1} - {w.vx0[XY_W-1], w.vx0};
  assign ay2 = {w.vy2[XY_W-1], w.vy2} - {w.vy0[XY_W-1], w.vy0};
  assign ax2 = {w.vx2[XY_W-1], w.vx2} - {w.vx0[XY_W-1], w.vx0};
  assign ay1 = {w.vy1[XY_W-1], w.vy1} - {w.vy0[XY_W-1], w.vy0};

  assign tx0 = pix_trunc(w.vx0);
  assign tx1 = pix_trunc(w.vx1);
  assign tx2 = pix_trunc(w.vx2);
  assign ty0 = pix_trunc(w.vy0);
  assign ty1 = pix_trunc(w.vy1);
  assign ty2 = pix_trunc(w.vy2);
  assign tmin_x = smin3(tx0, tx1, tx2);
  assign tmax_x = smax3(tx0, tx1, tx2);
  assign tmin_y = smin3(ty0, ty1, ty2);
  assign tmax_y = smax3(ty0, ty1, ty2);
  assign emin_x = LIM_W'(tmin_x);
  assign emax_x = LIM_W'(tmax_x);
  assign emin_y = LIM_W'(tmin_y);
  assign emax_y = LIM_W'(tmax_y);

  assign area = {pa[33], pa} - {pb[33], pb};
  assign qx   = LIM_W'(tx0);
  assign qy   = LIM_W'(ty0);
  assign q_out = (qx < 0) || (qx > lim_x) || (qy < 0) || (qy > lim_y);
  assign box_empty = (bxa > bxb) || (bya > byb);

  assign accept = start && !busy;

  always_comb begin
    ent          = '0;
    ent.kind     = CMD_NONE;
    ent.x0       = w.vx0;
    ent.y0       = w.vy0;
    ent.z0       = w.vz0;
    ent.x1       = w.vx1;
    ent.y1       = w.vy1;
    ent.z1       = w.vz1;
    ent.x2       = w.vx2;
    ent.y2       = w.vy2;
    ent.z2       = w.vz2;
    ent.area_neg = area[AREA_W-1];
    ent.area     = area[AREA_W-1] ? AREA_W'(-area) : AREA_W'(area);
    case (w.op)
      OP_CLEAR: begin
        ent.kind = CMD_CLEAR;
      end
      OP_TRI: begin
        if (area == '0) ent.kind = CMD_DEGEN;
        else if (box_empty) ent.kind = CMD_NONE;
        else ent.kind = CMD_TRI;
        ent.xa = bxa[PIX_W-1:0];
        ent.xb = bxb[PIX_W-1:0];
        ent.ya = bya[PIX_W-1:0];
        ent.yb = byb[PIX_W-1:0];
      end
      OP_QUERY: begin
        ent.kind = q_out ? CMD_OUTSIDE : CMD_QUERY;
        ent.xa   = qx[PIX_W-1:0];
        ent.xb   = qx[PIX_W-1:0];
        ent.ya   = qy[PIX_W-1:0];
        ent.yb   = qy[PIX_W-1:0];
      end
      default: begin
        ent.kind = CMD_NONE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (accept) state_next = F_CALC;
      F_CALC:  state_next = F_PUSH;
      F_PUSH:  if (!q_stat.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != F_IDLE) || hold;
    q_in.push = (state == F_PUSH) && !q_stat.full;
    q_in.data = ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) w <= cmd;
    if (state == F_CALC) begin
      pa  <= ax1 * ay2;
      pb  <= ax2 * ay1;
      bxa <= (emin_x < 0) ? '0 : emin_x;
      bya <= (emin_y < 0) ? '0 : emin_y;
      bxb <= (emax_x > lim_x) ? lim_x : emax_x;
      byb <= (emax_y > lim_y) ? lim_y : emax_y;
    end
  end

endmodule

// ===== sv/drst_fifo.sv =====
module drst_fifo import drst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_push_t   q_in,
  input  logic      pop,
  output q_status_t q_stat,
  output entry_t    head
);

  entry_t slots [Q_DEPTH];
  logic [Q_AW-1:0] wp, rp;
  logic [Q_AW:0]   cnt;

  assign q_stat.full  = (cnt == (Q_AW+1)'(Q_DEPTH));
  assign q_stat.empty = (cnt == '0);
  assign head         = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (q_in.push) wp <= (wp == Q_AW'(Q_DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == Q_AW'(Q_DEPTH-1)) ? '0 : rp + 1'b1;
      case ({q_in.push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_in.push) slots[wp] <= q_in.data;
  end

endmodule

// ===== sv/drst_back.sv =====
module drst_back import drst_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  entry_t            head,
  input  q_status_t         q_stat,
  input  logic [BIAS_W-1:0] depth_bias,
  output logic              pop,
  output logic              sweeping,
  output logic              done,
  output res_word_t         result
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [Z_W-1:0] mem [DEPTH];

  back_state_t state, state_next;
  logic init;
  logic [AW-1:0] clr_addr;

  entry_t ent;
  logic [PIX_W-1:0] x, y;
  logic [2:0] k;
  logic [4:0] dcnt;
  logic signed [PROD_W-1:0] prod;
  logic signed [35:0] tmp;
  logic signed [E_W-1:0] e0, e1, e2;
  logic signed [NUM_W-1:0] num;
  logic [MAG_W-1:0] rem, dsr;
  logic [Z_W-1:0] quo, rd_q;
  logic qneg;
  logic [CNT_W-1:0] cnt;

  logic [AW-1:0] pix_addr;
  logic signed [17:0] dx0, dx1, dx2, dy0, dy1, dy2;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [E_W-1:0] edge_raw, edge_val;
  logic signed [NUM_W-1:0] lo_term, hi_term;
  logic [Z_W-1:0] dval;
  logic covered, last_pix, better, shadow;
  logic signed [Z_W:0] qdiff;
  logic [Z_W:0] qmag;
  logic mem_we, fin;
  logic [AW-1:0] mem_wa;
  logic [Z_W-1:0] mem_wd;
  res_word_t fin_res;

  assign pix_addr = AW'(int'(y) * MAX_WIDTH + int'(x));

  assign dx0 = {{2{ent.x0[XY_W-1]}}, ent.x0} - {3'b000, x, 4'b0000};
  assign dx1 = {{2{ent.x1[XY_W-1]}}, ent.x1} - {3'b000, x, 4'b0000};
  assign dx2 = {{2{ent.x2[XY_W-1]}}, ent.x2} - {3'b000, x, 4'b0000};
  assign dy0 = {{2{ent.y0[XY_W-1]}}, ent.y0} - {3'b000, y, 4'b0000};
  assign dy1 = {{2{ent.y1[XY_W-1]}}, ent.y1} - {3'b000, y, 4'b0000};
  assign dy2 = {{2{ent.y2[XY_W-1]}}, ent.y2} - {3'b000, y, 4'b0000};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == B_EDGE) begin
      case (k)
        3'd0: begin mul_a = MUL_AW'(dx1); mul_b = MUL_BW'(dy2); end
        3'd1: begin mul_a = MUL_AW'(dx2); mul_b = MUL_BW'(dy1); end
        3'd2: begin mul_a = MUL_AW'(dx2); mul_b = MUL_BW'(dy0); end
        3'd3: begin mul_a = MUL_AW'(dx0); mul_b = MUL_BW'(dy2); end
        3'd4: begin mul_a = MUL_AW'(dx0); mul_b = MUL_BW'(dy1); end
        3'd5: begin mul_a = MUL_AW'(dx1); mul_b = MUL_BW'(dy0); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == B_DEPTH) begin
      case (k)
        3'd0: begin mul_a = {1'b0, e0[17:0]};  mul_b = MUL_BW'(ent.z0); end
        3'd1: begin mul_a = {1'b0, e0[35:18]}; mul_b = MUL_BW'(ent.z0); end
        3'd2: begin mul_a = {1'b0, e1[17:0]};  mul_b = MUL_BW'(ent.z1); end
        3'd3: begin mul_a = {1'b0, e1[35:18]}; mul_b = MUL_BW'(ent.z1); end
        3'd4: begin mul_a = {1'b0, e2[17:0]};  mul_b = MUL_BW'(ent.z2); end
        3'd5: begin mul_a = {1'b0, e2[35:18]}; mul_b = MUL_BW'(ent.z2); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign edge_raw = {tmp[35], tmp} - {prod[35], prod[35:0]};
  assign edge_val = ent.area_neg ? -edge_raw : edge_raw;
  assign lo_term  = NUM_W'(prod);
  assign hi_term  = lo_term <<< 18;
  assign covered  = !e0[E_W-1] && !e1[E_W-1] && !e2[E_W-1];
  assign last_pix = (x == ent.xb) && (y == ent.yb);
  assign dval     = qneg ? Z_W'(-quo) : quo;
  assign better   = signed'(dval) < signed'(rd_q);
  assign qdiff    = {ent.z0[Z_W-1], ent.z0} - {rd_q[Z_W-1], rd_q};
  assign qmag     = qdiff[Z_W] ? (Z_W+1)'(-qdiff) : (Z_W+1)'(qdiff);
  assign shadow   = qmag > {2'b00, depth_bias};

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: if (clr_addr == LAST_ADDR) state_next = B_IDLE;
      B_IDLE: begin
        if (!q_stat.empty) begin
          case (head.kind)
            CMD_CLEAR: state_next = B_CLEAR;
            CMD_TRI:   state_next = B_EDGE;
            CMD_QUERY: state_next = B_QREAD;
            default:   state_next = B_IDLE;
          endcase
        end
      end
      B_QREAD:   state_next = B_QCMP;
      B_QCMP:    state_next = B_IDLE;
      B_EDGE:    if (k == 3'd6) state_next = B_COVER;
      B_COVER:   state_next = covered ? B_DEPTH : B_NEXT;
      B_DEPTH:   if (k == 3'd6) state_next = B_DIVINIT;
      B_DIVINIT: state_next = B_DIV;
      B_DIV:     if (dcnt == '0) state_next = B_WRITE;
      B_WRITE:   state_next = B_NEXT;
      B_NEXT:    state_next = last_pix ? B_IDLE : B_EDGE;
      default:   state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = pix_addr;
    mem_wd  = dval;
    fin     = 1'b0;
    fin_res = '0;
    case (state)
      B_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = DEPTH_MAX;
        fin    = (clr_addr == LAST_ADDR) && !init;
      end
      B_IDLE: begin
        pop = !q_stat.empty;
        if (!q_stat.empty) begin
          case (head.kind)
            CMD_NONE:    fin = 1'b1;
            CMD_DEGEN:   begin fin = 1'b1; fin_res.degenerate = 1'b1; end
            CMD_OUTSIDE: begin fin = 1'b1; fin_res.outside_map = 1'b1; end
            default:     fin = 1'b0;
          endcase
        end
      end
      B_QCMP: begin
        fin               = 1'b1;
        fin_res.in_shadow = shadow;
      end
      B_WRITE: begin
        mem_we = better;
      end
      B_NEXT: begin
        fin                    = last_pix;
        fin_res.pixels_written = cnt;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  assign sweeping = init;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      init     <= 1'b1;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == B_CLEAR) begin
        clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) init <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= fin_res;
    prod   <= mul_a * mul_b;
    case (state)
      B_IDLE: begin
        if (pop) begin
          ent <= head;
          x   <= head.xa;
          y   <= head.ya;
          k   <= '0;
          cnt <= '0;
        end
      end
      B_EDGE: begin
        k <= k + 1'b1;
        if (k != '0) begin
          if (k[0]) tmp <= prod[35:0];
          else begin
            case (k)
              3'd2:    e0 <= edge_val;
              3'd4:    e1 <= edge_val;
              default: e2 <= edge_val;
            endcase
          end
        end
      end
      B_COVER: begin
        k   <= '0;
        num <= '0;
      end
      B_DEPTH: begin
        k <= k + 1'b1;
        if (k != '0) num <= num + (k[0] ? lo_term : hi_term);
      end
      B_DIVINIT: begin
        qneg <= num[NUM_W-1];
        rem  <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        dsr  <= MAG_W'({ent.area, 23'b0});
        quo  <= '0;
        dcnt <= 5'd23;
      end
      B_DIV: begin
        if (rem >= dsr) begin
          rem <= rem - dsr;
          quo <= {quo[Z_W-2:0], 1'b1};
        end else begin
          quo <= {quo[Z_W-2:0], 1'b0};
        end
        dsr  <= dsr >> 1;
        dcnt <= dcnt - 1'b1;
      end
      B_WRITE: begin
        if (better && cnt != CNT_MAX) cnt <= cnt + 1'b1;
      end
      B_NEXT: begin
        k <= '0;
        if (!last_pix) begin
          if (x == ent.xb) begin
            x <= ent.xa;
            y <= y + 1'b1;
          end else begin
            x <= x + 1'b1;
          end
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[pix_addr];
  end

endmodule

// ===== bench/depth_map_rasterizer_shadow_test_checker.sv =====
module depth_map_rasterizer_shadow_test_checker import drst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  in_word_t          cmd,
  input  logic              done,
  input  res_word_t         result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [BIAS_W-1:0] cfg_data,
  output int                errors,
  output int                pending
);

  localparam int MAP_COLS = DEF_MAX_WIDTH;
  localparam int MAP_ROWS = DEF_MAX_HEIGHT;

  logic signed [Z_W-1:0] depth_mem [0:MAP_COLS*MAP_ROWS-1];
  logic [DIM_W-1:0]      cols_reg;
  logic [DIM_W-1:0]      rows_reg;
  logic [BIAS_W-1:0]     bias_reg;
  res_word_t             expected_q [$];

  assign pending = expected_q.size();

  function automatic void fill_depth_max();
    for (int i = 0; i < MAP_COLS*MAP_ROWS; i++) depth_mem[i] = DEPTH_MAX;
  endfunction

  function automatic int cols_used();
    return (cols_reg > MAP_COLS) ? MAP_COLS : int'(cols_reg);
  endfunction

  function automatic int rows_used();
    return (rows_reg > MAP_ROWS) ? MAP_ROWS : int'(rows_reg);
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // rasterize into the shadow copy of the map, return the result word
  function automatic res_word_t draw_triangle(in_word_t w);
    res_word_t r;
    longint x0, y0, z0, x1, y1, z1, x2, y2, z2;
    longint area, sgn, px, py, e0, e1, e2, d;
    longint xa, xb, ya, yb;
    int cnt, idx;
    r = '0;
    x0 = w.vx0; y0 = w.vy0; z0 = w.vz0;
    x1 = w.vx1; y1 = w.vy1; z1 = w.vz1;
    x2 = w.vx2; y2 = w.vy2; z2 = w.vz2;
    area = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
    if (area == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    sgn = (area < 0) ? -1 : 1;
    area = area * sgn;
    // longint division truncates toward zero, same as pixel truncation
    xa = min3(x0, x1, x2) / 16;
    xb = max3(x0, x1, x2) / 16;
    ya = min3(y0, y1, y2) / 16;
    yb = max3(y0, y1, y2) / 16;
    if (xa < 0) xa = 0;
    if (ya < 0) ya = 0;
    if (xb > cols_used() - 1) xb = cols_used() - 1;
    if (yb > rows_used() - 1) yb = rows_used() - 1;
    cnt = 0;
    for (longint x = xa; x <= xb; x++) begin
      for (longint y = ya; y <= yb; y++) begin
        px = x * 16;
        py = y * 16;
        e0 = sgn * ((x1 - px) * (y2 - py) - (x2 - px) * (y1 - py));
        e1 = sgn * ((x2 - px) * (y0 - py) - (x0 - px) * (y2 - py));
        e2 = sgn * ((x0 - px) * (y1 - py) - (x1 - px) * (y0 - py));
        if (e0 >= 0 && e1 >= 0 && e2 >= 0) begin
          d = (e0 * z0 + e1 * z1 + e2 * z2) / area;
          idx = int'(y) * MAP_COLS + int'(x);
          if (d < longint'(depth_mem[idx])) begin
            depth_mem[idx] = d[Z_W-1:0];
            if (cnt < 131071) cnt++;
          end
        end
      end
    end
    r.pixels_written = cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic res_word_t test_shadow(in_word_t w);
    res_word_t r;
    longint qx, qy, diff;
    r = '0;
    qx = longint'(w.vx0) / 16;
    qy = longint'(w.vy0) / 16;
    if (qx < 0 || qy < 0 || qx >= cols_used() || qy >= rows_used()) begin
      r.outside_map = 1'b1;
      return r;
    end
    diff = longint'(w.vz0) - longint'(depth_mem[int'(qy) * MAP_COLS + int'(qx)]);
    if (diff < 0) diff = -diff;
    r.in_shadow = (diff > longint'(bias_reg));
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cols_reg <= 9'd256;
      rows_reg <= 9'd256;
      bias_reg <= 23'd4194;
      fill_depth_max();
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_MAP_WIDTH:  cols_reg <= cfg_data[DIM_W-1:0];
          REG_MAP_HEIGHT: rows_reg <= cfg_data[DIM_W-1:0];
          REG_DEPTH_BIAS: bias_reg <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (op_t'(cmd.op))
          OP_CLEAR: begin
            fill_depth_max();
            expected_q.push_back('0);
          end
          OP_TRI:   expected_q.push_back(draw_triangle(cmd));
          OP_QUERY: expected_q.push_back(test_shadow(cmd));
          default:  expected_q.push_back('0);
        endcase
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word with none expected: got %p", $time, result);
          errors <= errors + 1;
        end else begin
          if (result !== expected_q[0]) begin
            $display("%0t: result mismatch: expected %p, got %p",
                     $time, expected_q[0], result);
            errors <= errors + 1;
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end

endmodule

// ===== bench/depth_map_rasterizer_shadow_test_tb.sv =====
module depth_map_rasterizer_shadow_test_tb;
  import drst_pkg::*;

  // index with no register behind it; writes must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  in_word_t          cmd = '0;
  logic              done;
  res_word_t         result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [BIAS_W-1:0] cfg_data = '0;
  int                errors;
  int                pending;

  // sender burst bookkeeping and a little coverage tally
  int burst_left = 0;
  int n_tri = 0, n_query = 0, n_clear = 0, n_other = 0;
  int last_z = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  depth_map_rasterizer_shadow_test dut (
    .clk, .rst, .start, .busy, .cmd, .done, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  depth_map_rasterizer_shadow_test_checker chk (
    .clk, .rst, .start, .busy, .cmd, .done, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // hard stop: reset sweep, a handful of clears and about 1500 random words,
  // many of them small triangles, fit far inside this
  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end

  // Offer one command word; leaves start high on return so a back-to-back
  // word keeps a single assignment per time step. Gaps drop start first.
  task automatic send_word(in_word_t w);
    if (burst_left == 0) begin
      // occasionally a long burst with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
    case (op_t'(w.op))
      OP_CLEAR: n_clear++;
      OP_TRI:   n_tri++;
      OP_QUERY: n_query++;
      default:  n_other++;
    endcase
  endtask

  // drop start and wait until every result word has come back
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [BIAS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_map(int cols, int rows, int bias);
    drain();
    write_reg(REG_MAP_WIDTH, BIAS_W'(cols));
    write_reg(REG_MAP_HEIGHT, BIAS_W'(rows));
    write_reg(REG_DEPTH_BIAS, BIAS_W'(bias));
  endtask

  function automatic in_word_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz);
    in_word_t w;
    w = '{op: OP_TRI, vx0: XY_W'(ax), vy0: XY_W'(ay), vz0: Z_W'(az),
          vx1: XY_W'(bx), vy1: XY_W'(by), vz1: Z_W'(bz),
          vx2: XY_W'(cx), vy2: XY_W'(cy), vz2: Z_W'(cz)};
    return w;
  endfunction

  function automatic in_word_t make_query(int qx, int qy, int qz);
    in_word_t w;
    w = '0;
    w.op = OP_QUERY;
    w.vx0 = XY_W'(qx);
    w.vy0 = XY_W'(qy);
    w.vz0 = Z_W'(qz);
    return w;
  endfunction

  // Random word. Most triangles are small and sit on or near the map so the
  // walk stays short; wide mode throws every triangle field and half the queries over their full range.
  function automatic in_word_t random_word(int cols, int rows, bit wide);
    in_word_t w;
    logic [191:0] raw;
    int pick, cx, cy, sz, base, spread;
    w = '0;
    pick = $urandom_range(0, 999);
    if (pick < 3) begin
      w.op = OP_CLEAR;
      w.vx0 = XY_W'($urandom);
    end else if (pick < 12) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(in_word_t)-1:0];
      w.op = OP_NONE;
    end else if (pick < 560) begin
      if (wide) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(in_word_t)-1:0];
      end else begin
        cx = $urandom_range(0, cols + 8) - 4;
        cy = $urandom_range(0, rows + 8) - 4;
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        base = int'($urandom_range(0, 16777215)) - 8388608;
        spread = $urandom_range(0, 200000);
        w = make_tri(cx * 16 + int'($urandom_range(0, 32 * sz)) - 16 * sz,
                     cy * 16 + int'($urandom_range(0, 32 * sz)) - 16 * sz,
                     base + int'($urandom_range(0, spread)),
                     cx * 16 + int'($urandom_range(0, 32 * sz)) - 16 * sz,
                     cy * 16 + int'($urandom_range(0, 32 * sz)) - 16 * sz,
                     base + int'($urandom_range(0, spread)),
                     cx * 16 + int'($urandom_range(0, 32 * sz)) - 16 * sz,
                     cy * 16 + int'($urandom_range(0, 32 * sz)) - 16 * sz,
                     base + int'($urandom_range(0, spread)));
      end
      // collinear or repeated vertices now and then
      case ($urandom_range(0, 11))
        0: begin w.vx2 = w.vx1; w.vy2 = w.vy1; end
        1: begin
          w.vx2 = w.vx0 + (w.vx1 - w.vx0) * 16'sd2;
          w.vy2 = w.vy0 + (w.vy1 - w.vy0) * 16'sd2;
        end
        default: ;
      endcase
      w.op = OP_TRI;
    end else begin
      if (wide && $urandom_range(0, 1)) begin
        w = make_query($urandom, $urandom, $urandom);
      end else begin
        w = make_query(int'($urandom_range(0, 16 * cols + 64)) - 32,
                       int'($urandom_range(0, 16 * rows + 64)) - 32,
                       $urandom_range(0, 1) ? int'($urandom)
                                            : last_z + int'($urandom_range(0, 16000)) - 8000);
      end
    end
    return w;
  endfunction

  task automatic random_run(int count, int cols, int rows, bit wide);
    in_word_t w;
    for (int i = 0; i < count; i++) begin
      w = random_word(cols, rows, wide);
      if (w.op == OP_TRI) last_z = w.vz0;
      send_word(w);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default map; touch every register plus the dead index
    write_reg(REG_UNUSED, '1);
    set_map(256, 256, 4194);

    // directed: untouched map, edges of the query space
    send_word(make_query(0, 0, 8388607));          // equal depth, lit
    send_word(make_query(0, 0, -8388608));         // far off, shadowed
    send_word(make_query(-1, -15, 0));             // just below zero: pixel 0
    send_word(make_query(-16, 0, 0));              // left of map
    send_word(make_query(256 * 16, 5, 0));         // right of map
    send_word(make_query(5, 32767, 0));
    send_word(make_query(-32768, -32768, 0));
    // counterclockwise, clockwise, degenerate and partly off-map triangles
    send_word(make_tri(16, 16, 1000, 96, 16, 2000, 16, 96, 3000));
    send_word(make_tri(32, 32, -5000, 32, 112, 7000, 112, 32, 0));
    send_word(make_tri(10, 10, 0, 40, 40, 0, 70, 70, 0));
    send_word(make_tri(-40, -40, -8388608, 60, -20, 8388607, -20, 60, 0));
    send_word(make_tri(4000, 4000, 0, 4200, 4000, 0, 4000, 4200, 0));
    send_word(make_query(40, 40, 1500));
    send_word(make_query(48, 48, 100));
    send_word(make_query(0, 0, -8388608));
    send_word({OP_NONE, {(XY_W*6 + Z_W*3){1'b1}}});
    send_word('0);                                 // clear
    send_word(make_query(40, 40, 8388607));

    random_run(650, 256, 256, 1'b0);

    // small map: full-range vertices and zero bias
    set_map(16, 8, 0);
    send_word(make_tri(-32768, -32768, -8388608, 32767, -32768, 8388607,
                       -32768, 32767, 0));
    send_word(make_tri(32767, 32767, 8388607, -32768, 32767, -1, 32767, -32768, 1));
    send_word(make_query(15 * 16 + 15, 7 * 16 + 15, 0));
    random_run(220, 16, 8, 1'b1);

    // empty map and maximum bias
    set_map(0, 256, 8388607);
    random_run(50, 16, 16, 1'b0);

    // sizes beyond the map limit act as the limit
    set_map(511, 300, 1);
    random_run(300, 256, 256, 1'b0);

    set_map(1, 1, $urandom_range(0, 8388607));
    random_run(100, 2, 2, 1'b0);

    set_map(256, 256, $urandom_range(0, 20000));
    random_run(150, 256, 256, 1'b0);

    drain();
    $display("Ran %0d triangles, %0d queries, %0d clears, %0d unknown words",
             n_tri, n_query, n_clear, n_other);
    $display("over six map/bias settings including empty, 1x1 and oversized maps");
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
